// ===== sv/pxe_pkg.sv =====
// Shared types, constants and character tables for the percent / xml escape encoder.
// No dependencies. Used by pxe_front, pxe_fifo, pxe_back and the top level.
package pxe_pkg;

  // how one input byte is carried out by the back end
  typedef enum logic [2:0] {
    CLS_LIT,
    CLS_PCT,
    CLS_AMP,
    CLS_LT,
    CLS_GT,
    CLS_QUOT,
    CLS_APOS
  } pxe_cls_e;

  // classified transaction between the front end and the back end
  typedef struct packed {
    logic [7:0] in_byte;
    pxe_cls_e   cls;
    logic       value_end;
  } pxe_item_t;

  localparam int unsigned IdxW = 3;

  localparam logic [7:0] HexDigits [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  // number of characters produced for one class
  function automatic logic [IdxW-1:0] run_len(input pxe_cls_e cls);
    logic [IdxW-1:0] len;
    case (cls)
      CLS_LIT:  len = 3'd1;
      CLS_PCT:  len = 3'd3;
      CLS_AMP:  len = 3'd5;
      CLS_LT:   len = 3'd4;
      CLS_GT:   len = 3'd4;
      CLS_QUOT: len = 3'd6;
      CLS_APOS: len = 3'd6;
      default:  len = 3'd1;
    endcase
    return len;
  endfunction

  // character at position idx of the run for one item
  function automatic logic [7:0] run_char(input pxe_item_t item, input logic [IdxW-1:0] idx);
    logic [7:0] ch;
    ch = item.in_byte;
    case (item.cls)
      CLS_LIT: ch = item.in_byte;
      CLS_PCT: begin
        case (idx)
          3'd0:    ch = "%";
          3'd1:    ch = HexDigits[item.in_byte[7:4]];
          default: ch = HexDigits[item.in_byte[3:0]];
        endcase
      end
      CLS_AMP: begin
        case (idx)
          3'd0:    ch = "&";
          3'd1:    ch = "a";
          3'd2:    ch = "m";
          3'd3:    ch = "p";
          default: ch = ";";
        endcase
      end
      CLS_LT: begin
        case (idx)
          3'd0:    ch = "&";
          3'd1:    ch = "l";
          3'd2:    ch = "t";
          default: ch = ";";
        endcase
      end
      CLS_GT: begin
        case (idx)
          3'd0:    ch = "&";
          3'd1:    ch = "g";
          3'd2:    ch = "t";
          default: ch = ";";
        endcase
      end
      CLS_QUOT: begin
        case (idx)
          3'd0:    ch = "&";
          3'd1:    ch = "q";
          3'd2:    ch = "u";
          3'd3:    ch = "o";
          3'd4:    ch = "t";
          default: ch = ";";
        endcase
      end
      CLS_APOS: begin
        case (idx)
          3'd0:    ch = "&";
          3'd1:    ch = "a";
          3'd2:    ch = "p";
          3'd3:    ch = "o";
          3'd4:    ch = "s";
          default: ch = ";";
        endcase
      end
      default: ch = item.in_byte;
    endcase
    return ch;
  endfunction

endpackage

// ===== sv/pxe_front.sv =====
// Front end: holds the mode register and classifies each incoming byte.
// Depends on pxe_pkg for the class enum and the item struct.
module pxe_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic [7:0]         in_byte_i,
  input  logic               value_end_i,
  output pxe_pkg::pxe_item_t item_o
);
  import pxe_pkg::*;

  logic     url_mode_q;
  pxe_cls_e cls;
  logic     unreserved;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      url_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      url_mode_q <= cfg_wdata_i;
    end
  end

  // unreserved set for percent encoding
  always_comb begin
    unreserved = ((in_byte_i >= "0") && (in_byte_i <= "9")) ||
                 ((in_byte_i >= "A") && (in_byte_i <= "Z")) ||
                 ((in_byte_i >= "a") && (in_byte_i <= "z")) ||
                 (in_byte_i == "-") || (in_byte_i == "_") ||
                 (in_byte_i == ".") || (in_byte_i == "~");
  end

  // class selection
  always_comb begin
    cls = CLS_LIT;
    if (url_mode_q) begin
      cls = unreserved ? CLS_LIT : CLS_PCT;
    end else begin
      case (in_byte_i)
        "&":     cls = CLS_AMP;
        "<":     cls = CLS_LT;
        ">":     cls = CLS_GT;
        8'h22:   cls = CLS_QUOT;
        8'h27:   cls = CLS_APOS;
        default: cls = CLS_LIT;
      endcase
    end
  end

  assign item_o = '{in_byte: in_byte_i, cls: cls, value_end: value_end_i};

endmodule

// ===== sv/pxe_fifo.sv =====
// Short queue of classified transactions between the front end and the back end.
// Depends on pxe_pkg for the item struct.
module pxe_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  pxe_pkg::pxe_item_t wdata_i,
  output logic               full_o,
  input  logic               rd_i,
  output pxe_pkg::pxe_item_t rdata_o,
  output logic               empty_o
);
  import pxe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  pxe_item_t       mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== sv/pxe_back.sv =====
// Back end: walks the run of each queued transaction, one character per cycle when not stalled.
// Depends on pxe_pkg for the item struct and the character tables.
module pxe_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pxe_pkg::pxe_item_t item_i,
  input  logic               item_empty_i,
  output logic               item_pop_o,
  output logic [7:0]         out_char_o,
  output logic               run_last_o,
  output logic               value_last_o,
  output logic               empty_o,
  input  logic               pop_i
);
  import pxe_pkg::*;

  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q;
  logic [7:0]      out_char_q;
  logic            run_last_q;
  logic            value_last_q;
  logic            advance;
  logic            last;

  // output register frees up when empty or when popped this cycle
  assign advance    = !item_empty_i && (!out_valid_q || pop_i);
  assign last       = (idx_q == run_len(item_i.cls) - 1'b1);
  assign item_pop_o = advance && last;

  // position within the current run
  always_comb begin
    idx_d = idx_q;
    if (advance) begin
      idx_d = last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_char_q   <= run_char(item_i, idx_q);
      run_last_q   <= last;
      value_last_q <= last && item_i.value_end;
    end
  end

  assign empty_o      = !out_valid_q;
  assign out_char_o   = out_char_q;
  assign run_last_o   = run_last_q;
  assign value_last_o = value_last_q;

endmodule

// ===== sv/percent_or_xml_escape_encoder.sv =====
// Top level of the percent / xml escape encoder: front end, item queue, back end.
// Depends on pxe_pkg, pxe_front, pxe_fifo and pxe_back.
//
//   channel   handshake          fields
//   input     push / full        in_byte_i, value_end_i
//   result    empty / pop        out_char_o, run_last_o, value_last_o
//   config    cfg_we_i           cfg_wdata_i (url mode)
//
// The back end emits one character per cycle while the result side pops, and a byte
// yields as many characters as its run: 1 for a plain byte, 3 for a percent triple,
// 4 to 6 for an entity. A byte passes through the queue storage and then the back end
// output register between push and its first character on the result ports.
// The queue lets input be taken while the result side stalls; full rises when it
// holds FifoDepth bytes. Reset clears the mode to xml escaping and empties all stages.
module percent_or_xml_escape_encoder #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       value_end_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char_o,
  output logic       run_last_o,
  output logic       value_last_o
);
  import pxe_pkg::*;

  pxe_item_t front_item;
  pxe_item_t head_item;
  logic      head_empty;
  logic      head_pop;

  // classify incoming bytes
  pxe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_byte_i   (in_byte_i),
    .value_end_i (value_end_i),
    .item_o      (front_item)
  );

  // decouple front and back
  pxe_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wdata_i (front_item),
    .full_o  (full),
    .rd_i    (head_pop),
    .rdata_o (head_item),
    .empty_o (head_empty)
  );

  // emit characters
  pxe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (head_item),
    .item_empty_i (head_empty),
    .item_pop_o   (head_pop),
    .out_char_o   (out_char_o),
    .run_last_o   (run_last_o),
    .value_last_o (value_last_o),
    .empty_o      (empty),
    .pop_i        (pop)
  );

endmodule

// ===== sim/tb_top.sv =====
// Testbench for percent_or_xml_escape_encoder: queue-fed input driver, result monitor and
// a built-in character predictor for both the percent and the xml escaping schemes.
// Depends only on the RTL top level percent_or_xml_escape_encoder and its sources.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned PhaseBytes  = 31;

  // bytes around the class boundaries of both schemes
  localparam logic [7:0] CornerBytes [24] = '{
    8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27, 8'h30, 8'h39, 8'h41,
    8'h5A, 8'h61, 8'h7A, 8'h2D, 8'h5F, 8'h2E, 8'h7E, 8'h2F,
    8'h3A, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h00, 8'hFF, 8'h80
  };

  typedef struct packed {
    logic [7:0] in_byte;
    logic       value_end;
  } raw_byte_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       value_last;
  } enc_char_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       push        = 1'b0;
  logic       full;
  logic [7:0] in_byte_i   = 8'h00;
  logic       value_end_i = 1'b0;
  logic       empty;
  logic       pop         = 1'b0;
  logic [7:0] out_char_o;
  logic       run_last_o;
  logic       value_last_o;

  percent_or_xml_escape_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .in_byte_i   (in_byte_i),
    .value_end_i (value_end_i),
    .empty       (empty),
    .pop         (pop),
    .out_char_o  (out_char_o),
    .run_last_o  (run_last_o),
    .value_last_o(value_last_o)
  );

  raw_byte_t   byte_q[$];
  enc_char_t   char_q[$];
  logic        url_mode_copy = 1'b0;
  int          err_cnt       = 0;
  int unsigned cycle_cnt     = 0;
  logic        in_taken      = 1'b0;
  logic        out_taken     = 1'b0;

  always #5 clk_i = ~clk_i;

  // letters, digits and - _ . ~ pass through percent encoding
  function automatic bit is_unreserved(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           c == "-" || c == "_" || c == "." || c == "~";
  endfunction

  // queue up the characters that one accepted byte must turn into
  function automatic void encode_byte(input logic [7:0] c, input logic last);
    logic [47:0]  run;
    logic [127:0] hexs;
    int           n;
    enc_char_t    r;
    hexs = "0123456789ABCDEF";
    run  = {40'd0, c};
    n    = 1;
    if (url_mode_copy) begin
      if (!is_unreserved(c)) begin
        run = {24'd0, "%", hexs[8*(15-c[7:4]) +: 8], hexs[8*(15-c[3:0]) +: 8]};
        n   = 3;
      end
    end else begin
      case (c)
        "&": begin
          run = "&amp;";
          n   = 5;
        end
        "<": begin
          run = "&lt;";
          n   = 4;
        end
        ">": begin
          run = "&gt;";
          n   = 4;
        end
        "\"": begin
          run = "&quot;";
          n   = 6;
        end
        "'": begin
          run = "&apos;";
          n   = 6;
        end
        default: ;
      endcase
    end
    for (int k = 0; k < n; k++) begin
      r.out_char   = run[8*(n-1-k) +: 8];
      r.run_last   = (k == n - 1);
      r.value_last = (k == n - 1) && last;
      char_q.push_back(r);
    end
  endfunction

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("percent_or_xml_escape_encoder test failed");
      $finish;
    end
  end

  // monitor: mode updates, accepted input bytes and accepted result characters
  always @(posedge clk_i) begin
    enc_char_t want;
    if (rst_ni) begin
      if (cfg_we_i) url_mode_copy = cfg_wdata_i;
      if (push && !full) encode_byte(in_byte_i, value_end_i);
      if (pop && !empty) begin
        if (char_q.size() == 0) begin
          $error("unexpected character out_char=%h run_last=%b value_last=%b",
                 out_char_o, run_last_o, value_last_o);
          err_cnt++;
        end else begin
          want = char_q.pop_front();
          if (out_char_o !== want.out_char) begin
            $error("out_char expected %h actual %h", want.out_char, out_char_o);
            err_cnt++;
          end
          if (run_last_o !== want.run_last) begin
            $error("run_last expected %b actual %b", want.run_last, run_last_o);
            err_cnt++;
          end
          if (value_last_o !== want.value_last) begin
            $error("value_last expected %b actual %b", want.value_last, value_last_o);
            err_cnt++;
          end
        end
      end
    end
    in_taken  <= rst_ni && push && !full;
    out_taken <= rst_ni && pop && !empty;
  end

  // input driver: one pending byte at a time, random gap before each
  raw_byte_t   cur_byte;
  bit          cur_ready = 1'b0;
  int unsigned gap_left  = 0;
  bit          gaps_on   = 1'b1;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (!push || in_taken) begin
      if (!cur_ready && byte_q.size() != 0) begin
        cur_byte  = byte_q.pop_front();
        cur_ready = 1'b1;
        if ($urandom_range(0, 19) == 0) gaps_on = !gaps_on;
        gap_left = gaps_on ? $urandom_range(0, 7) : 0;
      end
      if (cur_ready && gap_left == 0) begin
        in_byte_i   <= cur_byte.in_byte;
        value_end_i <= cur_byte.value_end;
        push        <= 1'b1;
        cur_ready = 1'b0;
      end else begin
        if (cur_ready) gap_left--;
        push <= 1'b0;
      end
    end
  end

  // result side: random stall after each accepted character
  int unsigned stall_left = 0;
  bit          stalls_on  = 1'b1;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (out_taken) begin
        if ($urandom_range(0, 15) == 0) stalls_on = !stalls_on;
        stall_left = stalls_on ? $urandom_range(0, 7) : 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic void send(input logic [7:0] b, input logic last);
    raw_byte_t t;
    t.in_byte   = b;
    t.value_end = last;
    byte_q.push_back(t);
  endfunction

  task automatic wait_idle();
    while (!(byte_q.size() == 0 && !cur_ready && !push && char_q.size() == 0))
      @(negedge clk_i);
  endtask

  // mode write only once nothing is in flight
  task automatic write_mode(input logic m);
    wait_idle();
    cfg_wdata_i <= m;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 3) == 0) return CornerBytes[$urandom_range(0, 23)];
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly whole values of 1 to 8 bytes, some bytes with a random end flag
  task automatic send_values(input int unsigned count);
    int unsigned sent;
    int unsigned len;
    logic        last;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 8);
      for (int unsigned i = 0; i < len; i++) begin
        last = (i == len - 1);
        if ($urandom_range(0, 9) == 0) last = 1'($urandom_range(0, 1));
        send(pick_byte(), last);
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // xml escaping out of reset: every entity, nul, top byte, plain bytes
    send("&", 1'b0);
    send("<", 1'b0);
    send(">", 1'b0);
    send("\"", 1'b0);
    send("'", 1'b1);
    send(8'h00, 1'b0);
    send(8'hFF, 1'b1);
    send("A", 1'b1);
    send("~", 1'b0);
    send("%", 1'b1);

    // percent encoding: nul, non-ascii, unreserved range ends, reserved bytes
    write_mode(1'b1);
    send(8'h00, 1'b0);
    send(8'hFF, 1'b0);
    send("0", 1'b0);
    send("9", 1'b0);
    send("A", 1'b0);
    send("Z", 1'b0);
    send("a", 1'b0);
    send("z", 1'b0);
    send("-", 1'b0);
    send("_", 1'b0);
    send(".", 1'b0);
    send("~", 1'b1);
    send("/", 1'b0);
    send("&", 1'b0);
    send(8'h80, 1'b1);

    // random phases across both modes
    write_mode(1'b0);
    send_values(PhaseBytes);
    write_mode(1'b1);
    send_values(PhaseBytes);
    write_mode(1'b1);
    send_values(PhaseBytes);
    write_mode(1'b0);
    send_values(PhaseBytes);
    write_mode(1'b1);
    send_values(PhaseBytes);
    write_mode(1'b0);
    send_values(PhaseBytes);

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0 && char_q.size() == 0) begin
      $display("percent_or_xml_escape_encoder test passed");
    end else begin
      $display("percent_or_xml_escape_encoder test failed");
    end
    $finish;
  end

endmodule
